### design/pidc_pkg.sv
package pidc_pkg;

    localparam int CFG_W           = 24;
    localparam int LIM_W           = 31;
    localparam int ISUM_W          = 32;
    localparam int TERM_W          = 62;
    localparam int Y_W             = 64;
    localparam int TERM_CAP_BIT    = 60;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [CFG_W-1:0] TICK_RST = 24'd10;

    typedef enum logic [2:0] {
        REG_GAIN,
        REG_INT_MS,
        REG_DER_MS,
        REG_TICK_MS,
        REG_OFFSET,
        REG_OUT_LOW,
        REG_OUT_HIGH,
        REG_INT_LIMIT
    } t_reg;

    typedef struct packed {
        logic [CFG_W-1:0] gain;
        logic [CFG_W-1:0] int_ms;
        logic [CFG_W-1:0] der_ms;
        logic [CFG_W-1:0] tick_ms;
        logic [LIM_W-1:0] int_limit;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_DERR,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_TERM,
        ST_IADD,
        ST_IHI,
        ST_ILO,
        ST_YP,
        ST_YI,
        ST_YD,
        ST_YLO,
        ST_YHI,
        ST_MAN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        JOB_INT,
        JOB_DER,
        JOB_PROP
    } t_job;

endpackage

### design/pid_controller_step_top.sv
// Positional PID controller, one request per control tick, with all values in signed
// Q(VALUE_WIDTH-FRAC_BITS).FRAC_BITS. The block works on one request at a time and
// holds its input stalled until the result is in the output register; the next request
// is taken while that result waits. The multiplies, divisions, sums and limit checks
// all run through one shared adder under a small sequencer: each multiply retires one
// multiplier bit per cycle and each division one quotient bit per cycle, so the
// integral and derivative divisions set the cost. A disabled integral or derivative
// term skips its multiplies and division, and a manual tick only adds the offset to
// the manual value, saturated to the value range. Configuration is to be written
// through the APB port only while the block is idle; the block does not enforce this.
module pid_controller_step_top #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = pidc_pkg::FRAC_BITS_DEF,
    parameter int DATA_W      = (VALUE_WIDTH > 32) ? 64 : 32,
    parameter int ADDR_W      = (VALUE_WIDTH > 32) ? 6 : 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [DATA_W-1:0]              pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0]  i_measured,
    input  logic signed [VALUE_WIDTH-1:0]  i_target,
    input  logic                           i_manual_on,
    input  logic                           i_clear_state,
    input  logic signed [VALUE_WIDTH-1:0]  i_manual_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]  o_drive,
    output logic                           o_limits_hit,
    output logic                           o_integral_saturated
);

    pidc_pkg::t_cfg                cfg;
    logic signed [VALUE_WIDTH-1:0] offset;
    logic signed [VALUE_WIDTH-1:0] out_low;
    logic signed [VALUE_WIDTH-1:0] out_high;

    assign pready = 1'b1;

    pidc_regs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .DATA_W      (DATA_W),
        .ADDR_W      (ADDR_W)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_cfg      (cfg),
        .o_offset   (offset),
        .o_out_low  (out_low),
        .o_out_high (out_high)
    );

    pidc_core #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg),
        .i_offset             (offset),
        .i_out_low            (out_low),
        .i_out_high           (out_high),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_measured           (i_measured),
        .i_target             (i_target),
        .i_manual_on          (i_manual_on),
        .i_clear_state        (i_clear_state),
        .i_manual_value       (i_manual_value),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_drive              (o_drive),
        .o_limits_hit         (o_limits_hit),
        .o_integral_saturated (o_integral_saturated)
    );

endmodule

### design/pidc_regs.sv
module pidc_regs #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = pidc_pkg::FRAC_BITS_DEF,
    parameter int DATA_W      = 32,
    parameter int ADDR_W      = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [DATA_W-1:0]              pwdata,
    output logic [DATA_W-1:0]              prdata,
    output pidc_pkg::t_cfg                 o_cfg,
    output logic signed [VALUE_WIDTH-1:0]  o_offset,
    output logic signed [VALUE_WIDTH-1:0]  o_out_low,
    output logic signed [VALUE_WIDTH-1:0]  o_out_high
);

    localparam int V  = VALUE_WIDTH;
    localparam int CW = pidc_pkg::CFG_W;
    localparam int LW = pidc_pkg::LIM_W;

    localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

    pidc_pkg::t_cfg        r_cfg;
    logic signed [V-1:0]   r_offset;
    logic signed [V-1:0]   r_low;
    logic signed [V-1:0]   r_high;
    pidc_pkg::t_reg        reg_idx;
    logic                  wr_en;

    assign reg_idx = pidc_pkg::t_reg'(paddr[ADDR_W-1 -: 3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain      <= CW'(1) << FRAC_BITS;
            r_cfg.int_ms    <= '0;
            r_cfg.der_ms    <= '0;
            r_cfg.tick_ms   <= pidc_pkg::TICK_RST;
            r_cfg.int_limit <= '1;
            r_offset        <= '0;
            r_low           <= VMIN;
            r_high          <= VMAX;
        end else if (wr_en) begin
            case (reg_idx)
                pidc_pkg::REG_GAIN:      r_cfg.gain      <= pwdata[CW-1:0];
                pidc_pkg::REG_INT_MS:    r_cfg.int_ms    <= pwdata[CW-1:0];
                pidc_pkg::REG_DER_MS:    r_cfg.der_ms    <= pwdata[CW-1:0];
                pidc_pkg::REG_TICK_MS:   r_cfg.tick_ms   <= pwdata[CW-1:0];
                pidc_pkg::REG_OFFSET:    r_offset        <= pwdata[V-1:0];
                pidc_pkg::REG_OUT_LOW:   r_low           <= pwdata[V-1:0];
                pidc_pkg::REG_OUT_HIGH:  r_high          <= pwdata[V-1:0];
                pidc_pkg::REG_INT_LIMIT: r_cfg.int_limit <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pidc_pkg::REG_GAIN:      prdata = DATA_W'(r_cfg.gain);
            pidc_pkg::REG_INT_MS:    prdata = DATA_W'(r_cfg.int_ms);
            pidc_pkg::REG_DER_MS:    prdata = DATA_W'(r_cfg.der_ms);
            pidc_pkg::REG_TICK_MS:   prdata = DATA_W'(r_cfg.tick_ms);
            pidc_pkg::REG_OFFSET:    prdata = DATA_W'(r_offset);
            pidc_pkg::REG_OUT_LOW:   prdata = DATA_W'(r_low);
            pidc_pkg::REG_OUT_HIGH:  prdata = DATA_W'(r_high);
            pidc_pkg::REG_INT_LIMIT: prdata = DATA_W'(r_cfg.int_limit);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg      = r_cfg;
    assign o_offset   = r_offset;
    assign o_out_low  = r_low;
    assign o_out_high = r_high;

endmodule

### design/pidc_core.sv
module pidc_core #(
    parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pidc_pkg::t_cfg                 i_cfg,
    input  logic signed [VALUE_WIDTH-1:0]  i_offset,
    input  logic signed [VALUE_WIDTH-1:0]  i_out_low,
    input  logic signed [VALUE_WIDTH-1:0]  i_out_high,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0]  i_measured,
    input  logic signed [VALUE_WIDTH-1:0]  i_target,
    input  logic                           i_manual_on,
    input  logic                           i_clear_state,
    input  logic signed [VALUE_WIDTH-1:0]  i_manual_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]  o_drive,
    output logic                           o_limits_hit,
    output logic                           o_integral_saturated
);

    localparam int V   = VALUE_WIDTH;
    localparam int CFW = pidc_pkg::CFG_W;
    localparam int EW  = V + 2;
    localparam int AW  = 2 * CFW;
    localparam int PW  = AW + EW;
    localparam int DW  = CFW + FRAC_BITS;
    localparam int MW  = (EW > CFW) ? EW : CFW;
    localparam int CW  = $clog2(PW + 1);
    localparam int SW  = PW;
    localparam int TW  = pidc_pkg::TERM_W;
    localparam int YW  = pidc_pkg::Y_W;
    localparam int IW  = pidc_pkg::ISUM_W;

    localparam logic [PW-1:0]       CAP  = PW'(1) << pidc_pkg::TERM_CAP_BIT;
    localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

    pidc_pkg::t_state       r_state, n_state;
    pidc_pkg::t_job         r_job, n_job;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [PW-1:0]          r_acc, n_acc;
    logic [AW-1:0]          r_a, n_a;
    logic [MW-1:0]          r_mpr, n_mpr;
    logic [DW-1:0]          r_rem, n_rem;
    logic [DW-1:0]          r_div, n_div;
    logic                   r_neg, n_neg;
    logic signed [V:0]      r_err, n_err;
    logic signed [EW-1:0]   r_derr, n_derr;
    logic signed [V:0]      r_last, n_last;
    logic signed [IW-1:0]   r_isum, n_isum;
    logic signed [TW-1:0]   r_term, n_term;
    logic signed [TW-1:0]   r_dterm, n_dterm;
    logic signed [YW-1:0]   r_y, n_y;
    logic                   r_sat, n_sat;
    logic                   r_lim_flag, n_lim_flag;
    logic signed [V-1:0]    r_meas;
    logic signed [V-1:0]    r_tgt;
    logic signed [V-1:0]    r_man;
    logic                   r_out_valid;
    logic signed [V-1:0]    r_drive;
    logic                   r_out_lim;
    logic                   r_out_sat;

    logic [SW-1:0]          alu_a;
    logic [SW-1:0]          alu_b;
    logic                   alu_sub;
    logic [SW-1:0]          alu_y;

    logic                   in_acc;
    logic                   out_load;
    logic                   en_int;
    logic                   en_der;
    logic [AW-1:0]          mpd;
    logic signed [EW-1:0]   err_ext;
    logic [EW-1:0]          err_mag;
    logic [EW-1:0]          derr_mag;
    logic [MW-1:0]          err_algn;
    logic [MW-1:0]          derr_algn;
    logic [PW-1:0]          mag_w;
    logic [PW-1:0]          term_mag;
    logic signed [IW-1:0]   lim_neg;

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign in_acc     = i_in_valid && (r_state == pidc_pkg::ST_IDLE);
    assign o_in_stall = (r_state != pidc_pkg::ST_IDLE);
    assign en_int     = (|i_cfg.int_ms) && (|i_cfg.tick_ms);
    assign en_der     = (|i_cfg.der_ms) && (|i_cfg.tick_ms);
    assign mpd        = (r_state == pidc_pkg::ST_MUL1) ? AW'(i_cfg.gain) : r_a;

    assign err_ext   = EW'(r_err);
    assign err_mag   = err_ext[EW-1] ? EW'(-err_ext) : EW'(err_ext);
    assign derr_mag  = r_derr[EW-1] ? EW'(-r_derr) : EW'(r_derr);
    assign err_algn  = MW'(err_mag) << (MW - EW);
    assign derr_algn = MW'(derr_mag) << (MW - EW);

    assign mag_w    = (r_job == pidc_pkg::JOB_PROP) ? (r_acc >> FRAC_BITS) : r_acc;
    assign term_mag = (mag_w > CAP) ? CAP : mag_w;
    assign lim_neg  = -$signed(IW'({1'b0, i_cfg.int_limit}));

    always_comb begin
        logic next_der;
        logic start_prop;
        n_state    = r_state;
        n_job      = r_job;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_a        = r_a;
        n_mpr      = r_mpr;
        n_rem      = r_rem;
        n_div      = r_div;
        n_neg      = r_neg;
        n_err      = r_err;
        n_derr     = r_derr;
        n_last     = r_last;
        n_isum     = r_isum;
        n_term     = r_term;
        n_dterm    = r_dterm;
        n_y        = r_y;
        n_sat      = r_sat;
        n_lim_flag = r_lim_flag;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;
        out_load   = 1'b0;
        next_der   = 1'b0;
        start_prop = 1'b0;

        case (r_state)
            pidc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_clear_state) begin
                        n_isum = '0;
                        n_last = '0;
                    end
                    n_state = i_manual_on ? pidc_pkg::ST_MAN : pidc_pkg::ST_ERR;
                end
            end
            pidc_pkg::ST_ERR: begin
                alu_a   = SW'(r_tgt);
                alu_b   = SW'(r_meas);
                alu_sub = 1'b1;
                n_err   = alu_y[V:0];
                n_state = pidc_pkg::ST_DERR;
            end
            pidc_pkg::ST_DERR: begin
                alu_a   = SW'(r_err);
                alu_b   = SW'(r_last);
                alu_sub = 1'b1;
                n_derr  = alu_y[EW-1:0];
                n_last  = r_err;
                if (en_int) begin
                    n_job   = pidc_pkg::JOB_INT;
                    n_state = pidc_pkg::ST_MUL1;
                    n_acc   = '0;
                    n_mpr   = MW'(i_cfg.tick_ms) << (MW - CFW);
                    n_cnt   = CW'(CFW);
                    n_div   = {i_cfg.int_ms, {FRAC_BITS{1'b0}}};
                    n_neg   = r_err[V];
                end else begin
                    n_isum   = '0;
                    next_der = 1'b1;
                end
            end
            pidc_pkg::ST_MUL1, pidc_pkg::ST_MUL2: begin
                alu_a = {r_acc[PW-2:0], 1'b0};
                alu_b = r_mpr[MW-1] ? SW'(mpd) : '0;
                n_acc = alu_y[PW-1:0];
                n_mpr = r_mpr << 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    if (r_state == pidc_pkg::ST_MUL1) begin
                        n_state = pidc_pkg::ST_MUL2;
                        n_a     = alu_y[AW-1:0];
                        n_acc   = '0;
                        n_mpr   = (r_job == pidc_pkg::JOB_INT) ? err_algn : derr_algn;
                        n_cnt   = CW'(EW);
                    end else if (r_job == pidc_pkg::JOB_PROP) begin
                        n_state = pidc_pkg::ST_TERM;
                    end else begin
                        n_state = pidc_pkg::ST_DIV;
                        n_cnt   = CW'(PW);
                        n_rem   = '0;
                    end
                end
            end
            pidc_pkg::ST_DIV: begin
                alu_a   = SW'({r_rem, r_acc[PW-1]});
                alu_b   = SW'(r_div);
                alu_sub = 1'b1;
                if (alu_y[SW-1]) begin
                    n_rem = {r_rem[DW-2:0], r_acc[PW-1]};
                    n_acc = {r_acc[PW-2:0], 1'b0};
                end else begin
                    n_rem = alu_y[DW-1:0];
                    n_acc = {r_acc[PW-2:0], 1'b1};
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = pidc_pkg::ST_TERM;
                end
            end
            pidc_pkg::ST_TERM: begin
                alu_b   = SW'(term_mag);
                alu_sub = r_neg;
                n_term  = alu_y[TW-1:0];
                case (r_job)
                    pidc_pkg::JOB_INT: begin
                        n_state = pidc_pkg::ST_IADD;
                    end
                    pidc_pkg::JOB_DER: begin
                        n_dterm    = alu_y[TW-1:0];
                        start_prop = 1'b1;
                    end
                    default: begin
                        n_state = pidc_pkg::ST_YP;
                    end
                endcase
            end
            pidc_pkg::ST_IADD: begin
                alu_a   = SW'(r_isum);
                alu_b   = SW'(r_term);
                n_y     = alu_y[YW-1:0];
                n_state = pidc_pkg::ST_IHI;
            end
            pidc_pkg::ST_IHI: begin
                alu_a   = SW'(i_cfg.int_limit);
                alu_b   = SW'(r_y);
                alu_sub = 1'b1;
                if (alu_y[SW-1]) begin
                    n_isum   = IW'({1'b0, i_cfg.int_limit});
                    n_sat    = 1'b1;
                    next_der = 1'b1;
                end else begin
                    n_state = pidc_pkg::ST_ILO;
                end
            end
            pidc_pkg::ST_ILO: begin
                alu_a = SW'(r_y);
                alu_b = SW'(i_cfg.int_limit);
                if (alu_y[SW-1]) begin
                    n_isum = lim_neg;
                    n_sat  = 1'b1;
                end else begin
                    n_isum = r_y[IW-1:0];
                    n_sat  = 1'b0;
                end
                next_der = 1'b1;
            end
            pidc_pkg::ST_YP: begin
                alu_a   = SW'(i_offset);
                alu_b   = SW'(r_term);
                n_y     = alu_y[YW-1:0];
                n_state = pidc_pkg::ST_YI;
            end
            pidc_pkg::ST_YI: begin
                alu_a   = SW'(r_y);
                alu_b   = SW'(r_isum);
                n_y     = alu_y[YW-1:0];
                n_state = pidc_pkg::ST_YD;
            end
            pidc_pkg::ST_YD: begin
                alu_a   = SW'(r_y);
                alu_b   = SW'(r_dterm);
                n_y     = alu_y[YW-1:0];
                n_state = pidc_pkg::ST_YLO;
            end
            pidc_pkg::ST_YLO: begin
                alu_a   = SW'(r_y);
                alu_b   = SW'(i_out_low);
                alu_sub = 1'b1;
                if (alu_y[SW-1]) begin
                    n_y        = YW'(i_out_low);
                    n_lim_flag = 1'b1;
                    n_state    = pidc_pkg::ST_DONE;
                end else begin
                    n_state = pidc_pkg::ST_YHI;
                end
            end
            pidc_pkg::ST_YHI: begin
                alu_a   = SW'(i_out_high);
                alu_b   = SW'(r_y);
                alu_sub = 1'b1;
                if (alu_y[SW-1]) begin
                    n_y        = YW'(i_out_high);
                    n_lim_flag = 1'b1;
                end else begin
                    n_lim_flag = 1'b0;
                end
                n_state = pidc_pkg::ST_DONE;
            end
            pidc_pkg::ST_MAN: begin
                alu_a  = SW'(r_man);
                alu_b  = SW'(i_offset);
                n_isum = '0;
                if (alu_y[V] != alu_y[V-1]) begin
                    n_y = alu_y[V] ? YW'(VMIN) : YW'(VMAX);
                end else begin
                    n_y = YW'($signed(alu_y[V-1:0]));
                end
                n_state = pidc_pkg::ST_DONE;
            end
            pidc_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = pidc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pidc_pkg::ST_IDLE;
            end
        endcase

        if (next_der) begin
            if (en_der) begin
                n_job   = pidc_pkg::JOB_DER;
                n_state = pidc_pkg::ST_MUL1;
                n_acc   = '0;
                n_mpr   = MW'(i_cfg.der_ms) << (MW - CFW);
                n_cnt   = CW'(CFW);
                n_div   = {i_cfg.tick_ms, {FRAC_BITS{1'b0}}};
                n_neg   = n_derr[EW-1];
            end else begin
                n_dterm    = '0;
                start_prop = 1'b1;
            end
        end

        if (start_prop) begin
            n_job   = pidc_pkg::JOB_PROP;
            n_state = pidc_pkg::ST_MUL2;
            n_acc   = '0;
            n_a     = AW'(i_cfg.gain);
            n_mpr   = err_algn;
            n_cnt   = CW'(EW);
            n_neg   = r_err[V];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidc_pkg::ST_IDLE;
            r_job       <= pidc_pkg::JOB_INT;
            r_cnt       <= '0;
            r_isum      <= '0;
            r_last      <= '0;
            r_sat       <= 1'b0;
            r_lim_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_job      <= n_job;
            r_cnt      <= n_cnt;
            r_isum     <= n_isum;
            r_last     <= n_last;
            r_sat      <= n_sat;
            r_lim_flag <= n_lim_flag;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_a     <= n_a;
        r_mpr   <= n_mpr;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_neg   <= n_neg;
        r_err   <= n_err;
        r_derr  <= n_derr;
        r_term  <= n_term;
        r_dterm <= n_dterm;
        r_y     <= n_y;
        if (in_acc) begin
            r_meas <= i_measured;
            r_tgt  <= i_target;
            r_man  <= i_manual_value;
        end
        if (out_load) begin
            r_drive   <= r_y[V-1:0];
            r_out_lim <= r_lim_flag;
            r_out_sat <= r_sat;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_drive              = r_drive;
    assign o_limits_hit         = r_out_lim;
    assign o_integral_saturated = r_out_sat;

endmodule
